// ===== rtl/escd_pkg.sv =====
`default_nettype none

package escd_pkg;

    // Sequence bytes
    localparam logic [7:0] ESC_CODE   = 8'h1b;
    localparam logic [7:0] LBRACKET   = 8'h5b;
    localparam logic [7:0] QMARK      = 8'h3f;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;

    // Receiver channels
    localparam int unsigned NUM_CHANNELS = 10;
    localparam int unsigned CHAN_W       = 4;

    // Default depth of the run queue between parser and serializer
    localparam int unsigned RUN_Q_DEPTH = 4;

    // One run of output bytes caused by one input item.
    // Byte order: ESC, '[', digit, data, cut short to last_idx + 1 bytes
    // with data always the final byte.
    typedef struct packed {
        logic [1:0]        last_idx;
        logic [7:0]        digit;
        logic [7:0]        data;
        logic [CHAN_W-1:0] channel;
    } t_run;

endpackage

`default_nettype wire

// ===== rtl/escape_sequence_channel_demux.sv =====
// Channel   Handshake               Payload
// input     push / full             i_rx_byte
// result    pop / empty             o_out_byte, o_out_channel, o_last_of_run
// config    i_cfg_valid/o_cfg_ready i_cfg_data (receiver mask)
//
// Each input item is parsed in the cycle it is accepted; an item is taken
// every cycle while the run queue has room. The serializer sends one byte per
// cycle while the receiver pops, so an item that replays n bytes fills n
// output slots (1 to 4); items that emit nothing fill none.
// Reset is synchronous and clears parser state, channel, mask and queues.
// A stalled output fills the run queue, which then raises full.
`default_nettype none

module escape_sequence_channel_demux import escd_pkg::*; #(
    parameter int unsigned RUN_DEPTH = RUN_Q_DEPTH
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    push,
    output      logic                    full,
    input  wire logic [7:0]              i_rx_byte,
    input  wire logic                    pop,
    output      logic                    empty,
    output      logic [7:0]              o_out_byte,
    output      logic [CHAN_W-1:0]       o_out_channel,
    output      logic                    o_last_of_run,
    input  wire logic                    i_cfg_valid,
    output      logic                    o_cfg_ready,
    input  wire logic [NUM_CHANNELS-1:0] i_cfg_data
);

    logic q_full;
    logic run_push;
    t_run run_in;
    logic run_valid;
    t_run run_head;
    logic run_take;

    assign full        = q_full;
    assign o_cfg_ready = 1'b1;

    escd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (push && !q_full),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_write (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_run_push  (run_push),
        .o_run       (run_in)
    );

    escd_run_q #(
        .DEPTH (RUN_DEPTH)
    ) u_run_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (run_push),
        .i_run   (run_in),
        .o_full  (q_full),
        .o_valid (run_valid),
        .o_run   (run_head),
        .i_take  (run_take)
    );

    escd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_run_valid   (run_valid),
        .i_run         (run_head),
        .o_run_take    (run_take),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_out_byte    (o_out_byte),
        .o_out_channel (o_out_channel),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

// ===== rtl/escd_front.sv =====
`default_nettype none

module escd_front import escd_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_accept,
    input  wire logic [7:0]              i_rx_byte,
    input  wire logic                    i_cfg_write,
    input  wire logic [NUM_CHANNELS-1:0] i_cfg_data,
    output      logic                    o_run_push,
    output      t_run                    o_run
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ESC,
        ST_BRACKET,
        ST_DIGIT
    } t_parse_state;

    t_parse_state              r_state, n_state;
    logic [7:0]                r_digit, n_digit;
    logic [CHAN_W-1:0]         r_channel, n_channel;
    logic [NUM_CHANNELS-1:0]   r_mask;
    logic                      emit;
    logic                      chan_on;

    // Channel is enabled when in range and its mask bit is set
    always_comb begin
        chan_on = 1'b0;
        if (r_channel < CHAN_W'(NUM_CHANNELS)) begin
            chan_on = r_mask[r_channel];
        end
    end

    // Classify the byte and advance the parser
    always_comb begin
        n_state          = r_state;
        n_digit          = r_digit;
        n_channel        = r_channel;
        emit             = 1'b0;
        o_run.last_idx   = 2'd0;
        o_run.digit      = r_digit;
        o_run.data       = i_rx_byte;
        o_run.channel    = r_channel;
        unique case (r_state)
            ST_IDLE: begin
                if (i_rx_byte == ESC_CODE) begin
                    n_state = ST_ESC;
                end else begin
                    emit = 1'b1;
                end
            end
            ST_ESC: begin
                if (i_rx_byte == LBRACKET) begin
                    n_state = ST_BRACKET;
                end else begin
                    n_state        = ST_IDLE;
                    emit           = 1'b1;
                    o_run.last_idx = 2'd1;
                end
            end
            ST_BRACKET: begin
                if (i_rx_byte >= DIGIT_ZERO && i_rx_byte <= DIGIT_NINE) begin
                    n_state = ST_DIGIT;
                    n_digit = i_rx_byte;
                end else begin
                    n_state        = ST_IDLE;
                    emit           = 1'b1;
                    o_run.last_idx = 2'd2;
                end
            end
            ST_DIGIT: begin
                n_state = ST_IDLE;
                if (i_rx_byte == QMARK) begin
                    n_channel = r_digit[CHAN_W-1:0];
                end else begin
                    emit           = 1'b1;
                    o_run.last_idx = 2'd3;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Drop runs for a disabled channel
    assign o_run_push = i_accept && emit && chan_on;

    // Hold parser state, channel and mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_digit   <= 8'd0;
            r_channel <= '0;
            r_mask    <= '0;
        end else begin
            if (i_accept) begin
                r_state   <= n_state;
                r_digit   <= n_digit;
                r_channel <= n_channel;
            end
            if (i_cfg_write) begin
                r_mask <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/escd_run_q.sv =====
`default_nettype none

module escd_run_q import escd_pkg::*; #(
    parameter int unsigned DEPTH = RUN_Q_DEPTH
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_run i_run,
    output      logic o_full,
    output      logic o_valid,
    output      t_run o_run,
    input  wire logic i_take
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_run             r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_take;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_run   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_take = i_take && o_valid;

    // Store pushed runs
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_run;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_take) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_take) begin
                r_count <= r_count + 1'b1;
            end else if (do_take && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/escd_back.sv =====
`default_nettype none

module escd_back import escd_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_run_valid,
    input  wire t_run              i_run,
    output      logic              o_run_take,
    input  wire logic              i_pop,
    output      logic              o_empty,
    output      logic [7:0]        o_out_byte,
    output      logic [CHAN_W-1:0] o_out_channel,
    output      logic              o_last_of_run
);

    logic [1:0]        r_idx;
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic [CHAN_W-1:0] r_out_channel;
    logic              r_out_last;
    logic              load;
    logic              is_last;
    logic [7:0]        cur_byte;

    // Load the output register when it is free or being drained
    assign load       = i_run_valid && (!r_out_valid || i_pop);
    assign is_last    = (r_idx == i_run.last_idx);
    assign o_run_take = load && is_last;

    // Pick the byte at the current position of the run
    always_comb begin
        cur_byte = i_run.data;
        if (!is_last) begin
            unique case (r_idx)
                2'd0:    cur_byte = ESC_CODE;
                2'd1:    cur_byte = LBRACKET;
                2'd2:    cur_byte = i_run.digit;
                default: cur_byte = i_run.data;
            endcase
        end
    end

    // Advance position and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx       <= is_last ? 2'd0 : r_idx + 2'd1;
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the output item
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte    <= cur_byte;
            r_out_channel <= i_run.channel;
            r_out_last    <= is_last;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_out_channel = r_out_channel;
    assign o_last_of_run = r_out_last;

endmodule

`default_nettype wire

// ===== dv/tb_escape_sequence_channel_demux.sv =====
`default_nettype none

module tb_escape_sequence_channel_demux;
    import escd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_HOLD   = 120;
    localparam int unsigned SETTLE      = 8;

    typedef enum logic [1:0] {
        PS_IDLE    = 2'd0,
        PS_ESC     = 2'd1,
        PS_BRACKET = 2'd2,
        PS_DIGIT   = 2'd3
    } t_parse_state;

    typedef struct packed {
        logic [7:0]        data;
        logic [CHAN_W-1:0] channel;
        logic              last;
    } t_delivery;

    // DUT connections, inputs known from time zero
    logic                    i_clk         = 1'b0;
    logic                    i_rst_n       = 1'b0;
    logic                    push          = 1'b0;
    logic                    full;
    logic [7:0]              i_rx_byte     = 8'h00;
    logic                    pop           = 1'b0;
    logic                    empty;
    logic [7:0]              o_out_byte;
    logic [CHAN_W-1:0]       o_out_channel;
    logic                    o_last_of_run;
    logic                    i_cfg_valid   = 1'b0;
    logic                    o_cfg_ready;
    logic [NUM_CHANNELS-1:0] i_cfg_data    = '0;

    // Predictor state
    t_parse_state            parse_st  = PS_IDLE;
    logic [7:0]              held_dig  = 8'h00;
    logic [CHAN_W-1:0]       cur_chan  = '0;
    logic [NUM_CHANNELS-1:0] rx_mask   = '0;

    // Byte stream still to send, deliveries still owed
    logic [7:0]              pending_rx [$];
    t_delivery               owed_deliveries [$];

    bit          feed_on      = 1'b0;
    bit          no_idle      = 1'b0;
    bit          hold_request = 1'b0;
    bit          byte_taken   = 1'b0;
    bit          result_taken = 1'b0;
    int unsigned send_gap     = 0;
    int unsigned recv_gap     = 0;
    int unsigned hold_left    = 0;
    int unsigned errors       = 0;
    int unsigned cycles       = 0;

    escape_sequence_channel_demux dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_rx_byte     (i_rx_byte),
        .pop           (pop),
        .empty         (empty),
        .o_out_byte    (o_out_byte),
        .o_out_channel (o_out_channel),
        .o_last_of_run (o_last_of_run),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Bound the run
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Advance the parser by one byte and queue the bytes it delivers
    task automatic predict_demux(input logic [7:0] c);
        logic [7:0] run_bytes [4];
        int         n;
        n = 0;
        case (parse_st)
            PS_IDLE: begin
                if (c == ESC_CODE) begin
                    parse_st = PS_ESC;
                end else begin
                    run_bytes[0] = c;
                    n = 1;
                end
            end
            PS_ESC: begin
                if (c == LBRACKET) begin
                    parse_st = PS_BRACKET;
                end else begin
                    parse_st = PS_IDLE;
                    run_bytes[0] = ESC_CODE;
                    run_bytes[1] = c;
                    n = 2;
                end
            end
            PS_BRACKET: begin
                if (c >= DIGIT_ZERO && c <= DIGIT_NINE) begin
                    parse_st = PS_DIGIT;
                    held_dig = c;
                end else begin
                    parse_st = PS_IDLE;
                    run_bytes[0] = ESC_CODE;
                    run_bytes[1] = LBRACKET;
                    run_bytes[2] = c;
                    n = 3;
                end
            end
            default: begin
                parse_st = PS_IDLE;
                if (c == QMARK) begin
                    cur_chan = CHAN_W'(held_dig - DIGIT_ZERO);
                end else begin
                    run_bytes[0] = ESC_CODE;
                    run_bytes[1] = LBRACKET;
                    run_bytes[2] = held_dig;
                    run_bytes[3] = c;
                    n = 4;
                end
            end
        endcase
        // Drop the whole run when the channel is not registered
        if (n > 0 && cur_chan < NUM_CHANNELS && rx_mask[cur_chan]) begin
            for (int k = 0; k < n; k++)
                owed_deliveries.push_back('{data: run_bytes[k], channel: cur_chan,
                                            last: (k == n - 1)});
        end
    endtask

    // Sample both handshakes at the rising edge
    always @(posedge i_clk) begin
        t_delivery want;
        if (feed_on) begin
            if (push && !full) begin
                predict_demux(i_rx_byte);
                byte_taken = 1'b1;
            end
            if (pop && !empty) begin
                result_taken = 1'b1;
                if (owed_deliveries.size() == 0) begin
                    $display("%0t: item expected none actual byte=%h channel=%0d last=%b",
                             $realtime, o_out_byte, o_out_channel, o_last_of_run);
                    errors++;
                end else begin
                    want = owed_deliveries.pop_front();
                    if (o_out_byte !== want.data) begin
                        $display("%0t: out_byte expected %h actual %h", $realtime,
                                 want.data, o_out_byte);
                        errors++;
                    end
                    if (o_out_channel !== want.channel) begin
                        $display("%0t: out_channel expected %0d actual %0d", $realtime,
                                 want.channel, o_out_channel);
                        errors++;
                    end
                    if (o_last_of_run !== want.last) begin
                        $display("%0t: last_of_run expected %b actual %b", $realtime,
                                 want.last, o_last_of_run);
                        errors++;
                    end
                end
            end
        end
    end

    // Driver: offer pending bytes, hold each until taken
    always @(negedge i_clk) begin
        if (!feed_on) begin
            push <= 1'b0;
        end else if (push && !byte_taken) begin
            // hold the offer
        end else if (send_gap > 0) begin
            send_gap--;
            push <= 1'b0;
        end else if (pending_rx.size() > 0) begin
            i_rx_byte <= pending_rx.pop_front();
            push      <= 1'b1;
            send_gap  = pick_gap();
        end else begin
            push <= 1'b0;
        end
        byte_taken = 1'b0;
    end

    // Receiver: pop with random gaps, long hold-off on request
    always @(negedge i_clk) begin
        if (!feed_on) begin
            pop <= 1'b0;
        end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = LONG_HOLD;
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (pop && !result_taken) begin
            // keep waiting for an item
        end else if (recv_gap > 0) begin
            recv_gap--;
            pop <= 1'b0;
        end else begin
            pop      <= 1'b1;
            recv_gap = pick_gap();
        end
        result_taken = 1'b0;
    end

    // Wait until every byte is sent and every delivery has arrived
    task automatic wait_drained();
        while (pending_rx.size() != 0 || push || owed_deliveries.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_receiver_mask(input logic [NUM_CHANNELS-1:0] mask);
        wait_drained();
        @(negedge i_clk);
        i_cfg_data  <= mask;
        i_cfg_valid <= 1'b1;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        rx_mask = mask;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_switch(input logic [7:0] dig);
        pending_rx.push_back(ESC_CODE);
        pending_rx.push_back(LBRACKET);
        pending_rx.push_back(dig);
        pending_rx.push_back(QMARK);
    endtask

    // Mostly well-formed sequences with random content, some noise
    task automatic queue_random(input int unsigned count);
        int unsigned r;
        int unsigned added;
        added = 0;
        while (added < count) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                queue_switch(DIGIT_ZERO + 8'($urandom_range(0, 9)));
                added += 4;
            end else if (r < 45) begin
                pending_rx.push_back(8'($urandom_range(0, 255)));
                added += 1;
            end else if (r < 55) begin
                repeat (3) pending_rx.push_back(8'($urandom_range(0, 255)));
                added += 3;
            end else if (r < 63) begin
                pending_rx.push_back(ESC_CODE);
                pending_rx.push_back(8'($urandom_range(0, 255)));
                added += 2;
            end else if (r < 71) begin
                pending_rx.push_back(ESC_CODE);
                pending_rx.push_back(LBRACKET);
                pending_rx.push_back(8'($urandom_range(0, 255)));
                added += 3;
            end else if (r < 83) begin
                // break after the digit, sometimes with ESC or a near-digit
                pending_rx.push_back(ESC_CODE);
                pending_rx.push_back(LBRACKET);
                pending_rx.push_back(DIGIT_ZERO + 8'($urandom_range(0, 9)));
                case ($urandom_range(0, 2))
                    0: pending_rx.push_back(ESC_CODE);
                    1: pending_rx.push_back(DIGIT_ZERO + 8'($urandom_range(0, 9)));
                    default: pending_rx.push_back(8'($urandom_range(0, 255)));
                endcase
                added += 4;
            end else if (r < 93) begin
                queue_switch(DIGIT_ZERO + 8'($urandom_range(0, 9)));
                repeat (2) pending_rx.push_back(8'($urandom_range(0, 255)));
                added += 6;
            end else begin
                repeat ($urandom_range(1, 3)) begin
                    pending_rx.push_back(ESC_CODE);
                    added += 1;
                end
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        feed_on = 1'b1;

        // Reset mask: channel not registered, everything dropped
        pending_rx.push_back(8'h41);
        pending_rx.push_back(ESC_CODE);
        pending_rx.push_back(8'h00);

        write_receiver_mask('1);
        // Field extremes and a plain byte
        pending_rx.push_back(8'h00);
        pending_rx.push_back(8'hff);
        pending_rx.push_back(8'h41);
        // ESC broken by a plain byte, then by another ESC
        pending_rx.push_back(ESC_CODE);
        pending_rx.push_back(8'h80);
        pending_rx.push_back(ESC_CODE);
        pending_rx.push_back(ESC_CODE);
        // ESC '[' broken by a plain byte and by ESC
        pending_rx.push_back(ESC_CODE);
        pending_rx.push_back(LBRACKET);
        pending_rx.push_back(8'h7f);
        pending_rx.push_back(ESC_CODE);
        pending_rx.push_back(LBRACKET);
        pending_rx.push_back(ESC_CODE);
        // Full partial replay of four bytes
        pending_rx.push_back(ESC_CODE);
        pending_rx.push_back(LBRACKET);
        pending_rx.push_back(DIGIT_ZERO + 8'd5);
        pending_rx.push_back(8'h5a);
        // Switch to the top channel, then deliver on it
        queue_switch(DIGIT_NINE);
        pending_rx.push_back(8'h55);
        queue_switch(DIGIT_ZERO);

        // Random phase with a long receiver hold to back up the block
        write_receiver_mask('1);
        hold_request = 1'b1;
        queue_random(25);

        write_receiver_mask(NUM_CHANNELS'($urandom_range(0, 1023)));
        queue_random(20);
        // Sender pause mid-phase until everything owed has come
        wait_drained();
        queue_random(15);

        write_receiver_mask('0);
        queue_random(15);

        write_receiver_mask(10'h2aa);
        queue_random(20);

        write_receiver_mask(NUM_CHANNELS'($urandom_range(0, 1023)) | 10'h001);
        queue_random(20);

        // Back-to-back stretch with no idling on either side
        write_receiver_mask('1);
        no_idle = 1'b1;
        queue_random(20);

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (errors == 0 && owed_deliveries.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
